// File: rtl/pwm_pkg.sv
// Shared types and constants for the prolate window multiplier.
// Holds field widths, register indexes, reset values and the Q0.40 window polynomial.
// No dependencies; every other file in rtl/ uses this package.
package pwm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned BW_W     = 24;
  localparam int unsigned WS_W     = 25;
  localparam int unsigned Q40_W    = 41;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned N_COEF   = 11;

  localparam int unsigned DEFAULT_MAX_LEN = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SCALE = 8'd1;

  localparam logic [BW_W-1:0] BIN_WIDTH_RST    = 24'd4096;
  localparam logic [WS_W-1:0] WINDOW_SCALE_RST = 25'd370727;

  // Window polynomial coefficients in u, highest power first, unsigned Q0.40.
  localparam logic [Q40_W-1:0] POLY_Q40 [N_COEF] = '{
    41'd59, 41'd2491, 41'd85844, 41'd2350031, 41'd49582309, 41'd775144232,
    41'd8511615643, 41'd60781692674, 41'd250180173501, 41'd477560827929,
    41'd251810723190
  };

  // Sideband that travels with every pipeline stage.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } side_t;

endpackage

// File: rtl/pwm_if.sv
// Handshake channel interfaces for the prolate window multiplier.
// Input item channel, result channel and configuration write channel.
// Depends on pwm_pkg for field widths.
interface pwm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwm_pkg::SAMPLE_W-1:0] sample;
  logic        [pwm_pkg::POS_W-1:0]    position;

  modport source (output valid, output sample, output position, input ready);
  modport sink   (input valid, input sample, input position, output ready);
endinterface

interface pwm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwm_pkg::SAMPLE_W-1:0] windowed;

  modport source (output valid, output windowed, input ready);
  modport sink   (input valid, input windowed, output ready);
endinterface

interface pwm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pwm_pkg::CFG_IDX_W-1:0]     index;
  logic [pwm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pwm_front.sv
// Front end of the window pipeline: bin centre and u = 1 - xt^2 in Q0.40.
// Four register stages, all advancing on the shared enable.
// Depends on pwm_pkg.
module pwm_front #(
  parameter int unsigned MAX_LEN = pwm_pkg::DEFAULT_MAX_LEN
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_take,
  input  logic signed [pwm_pkg::SAMPLE_W-1:0] sample,
  input  logic        [pwm_pkg::POS_W-1:0]    position,
  input  logic        [pwm_pkg::BW_W-1:0]     bin_width,
  output logic        [pwm_pkg::Q40_W-1:0]    u,
  output pwm_pkg::side_t                      side
);

  localparam logic [16:0] MAX_LEN_V = 17'(MAX_LEN);

  pwm_pkg::side_t side1_r, side2_r, side3_r, side4_r, side1_nxt;
  logic [pwm_pkg::POS_W-1:0] pos_c;
  logic [36:0] t_r, t_nxt;
  logic [36:0] a_full;
  logic [23:0] a_r;
  logic        zero2_r, zero3_r;
  logic [47:0] sq_r;
  logic [48:0] diff;
  logic [pwm_pkg::Q40_W-1:0] u_r, u_nxt;

  // Positions past the frame length use the last bin.
  always_comb begin
    if ({5'b0, position} >= MAX_LEN_V) begin
      pos_c = pwm_pkg::POS_W'(MAX_LEN_V - 17'd1);
    end else begin
      pos_c = position;
    end
    t_nxt = 37'({pos_c, 1'b1}) * 37'(bin_width);
    side1_nxt.valid  = in_take;
    side1_nxt.sample = sample;
  end

  always_comb begin
    if (t_r >= 37'h1000000) begin
      a_full = t_r - 37'h1000000;
    end else begin
      a_full = 37'h1000000 - t_r;
    end
  end

  always_comb begin
    diff  = 49'h1000000000000 - 49'(sq_r) + 49'd128;
    u_nxt = zero3_r ? '0 : diff[48:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
      side4_r.valid <= 1'b0;
    end else if (en) begin
      side1_r <= side1_nxt;
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t_nxt;
      a_r     <= a_full[23:0];
      zero2_r <= |a_full[36:24];
      sq_r    <= 48'(a_r) * 48'(a_r);
      zero3_r <= zero2_r;
      u_r     <= u_nxt;
    end
  end

  assign u    = u_r;
  assign side = side4_r;

endmodule

// File: rtl/pwm_horner.sv
// One Horner step acc' = round(acc * u / 2^40) + coef in unsigned Q0.40.
// Stage one forms four half-by-half partial products; stage two sums and rounds.
// Depends on pwm_pkg.
module pwm_horner (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [pwm_pkg::Q40_W-1:0]        coef,
  input  logic [pwm_pkg::Q40_W-1:0]        acc_in,
  input  logic [pwm_pkg::Q40_W-1:0]        u_in,
  input  pwm_pkg::side_t                   side_in,
  output logic [pwm_pkg::Q40_W-1:0]        acc_out,
  output logic [pwm_pkg::Q40_W-1:0]        u_out,
  output pwm_pkg::side_t                   side_out
);

  pwm_pkg::side_t side1_r, side2_r;
  logic [pwm_pkg::Q40_W-1:0] u1_r, u2_r;
  logic [41:0] p_hh_r;
  logic [40:0] p_lh_r, p_hl_r;
  logic [39:0] p_ll_r;
  logic [61:0] q, rnd;
  logic [pwm_pkg::Q40_W-1:0] acc_r, acc_nxt;

  // The low product only contributes its upper half, as in the split multiply.
  always_comb begin
    q = {p_hh_r, 20'b0} + 62'(p_lh_r) + 62'(p_hl_r) + 62'(p_ll_r[39:20]);
    rnd = q + 62'd524288;
    acc_nxt = pwm_pkg::Q40_W'(rnd[61:20] + 42'(coef));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
    end else if (en) begin
      side1_r <= side_in;
      side2_r <= side1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hh_r <= 42'(acc_in[40:20]) * 42'(u_in[40:20]);
      p_lh_r <= 41'(acc_in[19:0]) * 41'(u_in[40:20]);
      p_hl_r <= 41'(acc_in[40:20]) * 41'(u_in[19:0]);
      p_ll_r <= 40'(acc_in[19:0]) * 40'(u_in[19:0]);
      u1_r   <= u_in;
      u2_r   <= u1_r;
      acc_r  <= acc_nxt;
    end
  end

  assign acc_out  = acc_r;
  assign u_out    = u2_r;
  assign side_out = side2_r;

endmodule

// File: rtl/pwm_back.sv
// Back end of the window pipeline: weight rounding, scaling, sample product.
// Five register stages; the last is the output register with rounding and saturation.
// Depends on pwm_pkg.
module pwm_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic        [pwm_pkg::Q40_W-1:0]    acc,
  input  pwm_pkg::side_t                      side_in,
  input  logic        [pwm_pkg::WS_W-1:0]     window_scale,
  output logic                                valid,
  output logic signed [pwm_pkg::SAMPLE_W-1:0] windowed
);

  pwm_pkg::side_t side1_r, side2_r, side3_r, side4_r;
  logic [41:0] w_full;
  logic [25:0] w_r;
  logic [50:0] ws_r, g_full;
  logic [26:0] g_r;
  logic signed [43:0] prod_r;
  logic signed [44:0] prod_rnd;
  logic signed [20:0] res;
  logic signed [pwm_pkg::SAMPLE_W-1:0] out_nxt, out_r;
  logic        valid_r;

  always_comb begin
    w_full   = 42'(acc) + 42'd32768;
    g_full   = ws_r + 51'd8388608;
    prod_rnd = 45'(prod_r) + 45'sd8388608;
    res      = 21'(prod_rnd >>> 24);
    if (res > 21'sd32767) begin
      out_nxt = 16'sh7fff;
    end else if (res < -21'sd32768) begin
      out_nxt = -16'sh8000;
    end else begin
      out_nxt = res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
      side4_r.valid <= 1'b0;
      valid_r       <= 1'b0;
    end else if (en) begin
      side1_r <= side_in;
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side3_r;
      valid_r <= side4_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r    <= w_full[41:16];
      ws_r   <= 51'(w_r) * 51'(window_scale);
      g_r    <= g_full[50:24];
      prod_r <= 44'(side3_r.sample) * $signed({17'b0, g_r});
      out_r  <= out_nxt;
    end
  end

  assign valid    = valid_r;
  assign windowed = out_r;

endmodule

// File: rtl/prolate_window_multiply.sv
// Top level of the prolate-spheroidal window multiplier.
// Depends on pwm_pkg, the channel interfaces in pwm_if, pwm_front, pwm_horner and pwm_back.
//
//   Channel | Direction | Payload                        | Handshake
//   in_s    | in        | sample [15:0] s, position [11:0] | valid/ready
//   out_m   | out       | windowed [15:0] s              | valid/ready
//   cfg_s   | in        | index [7:0], data [24:0]       | valid/ready, always ready
//
// One item enters per clock unless the pipeline is stalled. The stages are four in
// front for the bin centre and u, two for each of the ten Horner steps (partial
// products, then sum and round), and five at the back ending in the output register.
// Reset (rst_n low at a clock edge) clears every valid bit and restores the registers.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a stall freezes every stage in place and nothing is lost or repeated.
module prolate_window_multiply #(
  parameter int unsigned MAX_LEN = pwm_pkg::DEFAULT_MAX_LEN
) (
  input  logic             clk,
  input  logic             rst_n,
  pwm_in_if.sink           in_s,
  pwm_out_if.source        out_m,
  pwm_cfg_if.sink          cfg_s
);

  localparam int unsigned N_STEP = pwm_pkg::N_COEF - 1;

  logic [pwm_pkg::BW_W-1:0] bin_width_r;
  logic [pwm_pkg::WS_W-1:0] window_scale_r;
  logic en;
  logic out_valid;

  logic [pwm_pkg::Q40_W-1:0] acc_c  [N_STEP+1];
  logic [pwm_pkg::Q40_W-1:0] u_c    [N_STEP+1];
  pwm_pkg::side_t            side_c [N_STEP+1];

  // Every stage moves on when the output register can take a new value.
  assign en          = !out_valid || out_m.ready;
  assign in_s.ready  = en;
  assign cfg_s.ready = 1'b1;
  assign out_m.valid = out_valid;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r    <= pwm_pkg::BIN_WIDTH_RST;
      window_scale_r <= pwm_pkg::WINDOW_SCALE_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        pwm_pkg::REG_BIN_WIDTH: begin
          bin_width_r <= cfg_s.data[pwm_pkg::BW_W-1:0];
        end
        pwm_pkg::REG_WINDOW_SCALE: begin
          window_scale_r <= cfg_s.data[pwm_pkg::WS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pwm_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_take   (in_s.valid),
    .sample    (in_s.sample),
    .position  (in_s.position),
    .bin_width (bin_width_r),
    .u         (u_c[0]),
    .side      (side_c[0])
  );

  // Horner's rule starts from the leading coefficient.
  assign acc_c[0] = pwm_pkg::POLY_Q40[0];

  for (genvar k = 0; k < N_STEP; k++) begin : g_step
    pwm_horner u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .coef     (pwm_pkg::POLY_Q40[k+1]),
      .acc_in   (acc_c[k]),
      .u_in     (u_c[k]),
      .side_in  (side_c[k]),
      .acc_out  (acc_c[k+1]),
      .u_out    (u_c[k+1]),
      .side_out (side_c[k+1])
    );
  end

  pwm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .acc          (acc_c[N_STEP]),
    .side_in      (side_c[N_STEP]),
    .window_scale (window_scale_r),
    .valid        (out_valid),
    .windowed     (out_m.windowed)
  );

endmodule

// File: test/prolate_window_multiply_tb.sv
// Self-checking testbench for prolate_window_multiply.
// Needs pwm_pkg, the channel interfaces in pwm_if.sv and the block itself.
// Results are compared with a bit-exact fixed-point predictor held in this file.
module prolate_window_multiply_tb;

  // Timing of the run. The pipeline is 29 stages deep; the end drain wait is sized
  // from that depth to cover any straggling item. The cycle limit is many times the
  // slowest plausible run of about two thousand items under heavy back-pressure.
  localparam int unsigned PIPE_LATENCY = 29;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned FRAME_MAX    = pwm_pkg::DEFAULT_MAX_LEN;
  localparam int unsigned DIRECTED_ROWS = 34;

  // An index that names no register; a write to it must change nothing.
  localparam logic [pwm_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFE;

  localparam longint unsigned ONE_Q24 = 64'd1 << 24;

  // Window polynomial in u, highest power first, unsigned Q0.40.
  localparam longint unsigned WEIGHT_COEF [11] = '{
    64'd59, 64'd2491, 64'd85844, 64'd2350031, 64'd49582309, 64'd775144232,
    64'd8511615643, 64'd60781692674, 64'd250180173501, 64'd477560827929,
    64'd251810723190
  };

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  // One line of the directed table: either a register write or an item, the
  // latter optionally carrying a result that is plain from the arithmetic.
  typedef struct {
    row_kind_t                           kind;
    logic [pwm_pkg::CFG_IDX_W-1:0]       index;
    logic [pwm_pkg::CFG_DATA_W-1:0]      data;
    logic signed [pwm_pkg::SAMPLE_W-1:0] smp;
    logic [pwm_pkg::POS_W-1:0]           pos;
    bit                                  known;
    logic signed [pwm_pkg::SAMPLE_W-1:0] known_val;
  } row_t;

  logic clk;
  logic rst_n;

  pwm_in_if  in_ch ();
  pwm_out_if out_ch ();
  pwm_cfg_if cfg_ch ();

  prolate_window_multiply dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  // The testbench's own copy of the two registers, updated at the clock edge
  // on which the block takes the write.
  logic [pwm_pkg::BW_W-1:0] bin_width_q;
  logic [pwm_pkg::WS_W-1:0] window_scale_q;

  // Windowed samples still owed by the block, oldest first.
  logic signed [pwm_pkg::SAMPLE_W-1:0] pending_windowed [$];

  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  row_t stim_table [DIRECTED_ROWS];

  // Free-running clock with a period of four units.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample times window weight, following the block's fixed-point recipe step by
  // step: bin centre, u = 1 - xt^2 in Q0.40, Horner's rule with a split multiply
  // whose low half is truncated before the final rounding, then the two scalings.
  function automatic logic signed [pwm_pkg::SAMPLE_W-1:0] window_product(
    input logic signed [pwm_pkg::SAMPLE_W-1:0] smp,
    input logic [pwm_pkg::POS_W-1:0]           pos_in
  );
    longint unsigned pos, t, a, u, acc, w, g, uh, ul, q;
    longint          res;
    int              k;
    pos = pos_in;
    if (pos >= FRAME_MAX) begin
      pos = FRAME_MAX - 1;
    end
    t = (2 * pos + 1) * longint'(bin_width_q);
    a = (t >= ONE_Q24) ? (t - ONE_Q24) : (ONE_Q24 - t);
    // Outside the frame the polynomial collapses to its constant term.
    if (a >= ONE_Q24) begin
      u = 0;
    end else begin
      u = ((64'd1 << 48) - a * a + 64'd128) >> 8;
    end
    acc = WEIGHT_COEF[0];
    uh  = u >> 20;
    ul  = u & 64'hFFFFF;
    for (k = 1; k < 11; k++) begin
      q   = acc * uh + ((acc * ul) >> 20);
      acc = ((q + (64'd1 << 19)) >> 20) + WEIGHT_COEF[k];
    end
    w   = (acc + (64'd1 << 15)) >> 16;
    g   = (w * longint'(window_scale_q) + (64'd1 << 23)) >> 24;
    res = (longint'(smp) * longint'(g) + (64'sd1 << 23)) >>> 24;
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    return res[pwm_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic row_t item_row(input logic signed [pwm_pkg::SAMPLE_W-1:0] smp,
                                    input logic [pwm_pkg::POS_W-1:0] pos);
    row_t r;
    r = '{ROW_ITEM, '0, '0, smp, pos, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t known_row(input logic signed [pwm_pkg::SAMPLE_W-1:0] smp,
                                     input logic [pwm_pkg::POS_W-1:0] pos,
                                     input logic signed [pwm_pkg::SAMPLE_W-1:0] val);
    row_t r;
    r = '{ROW_ITEM, '0, '0, smp, pos, 1'b1, val};
    return r;
  endfunction

  function automatic row_t write_row(input logic [pwm_pkg::CFG_IDX_W-1:0] index,
                                     input logic [pwm_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '{ROW_WRITE, index, data, '0, '0, 1'b0, '0};
    return r;
  endfunction

  // Offers one item, idling first at the current sender rate, and records what
  // the block owes for it once the item has been taken.
  task automatic push_item(input logic signed [pwm_pkg::SAMPLE_W-1:0] smp,
                           input logic [pwm_pkg::POS_W-1:0] pos,
                           input bit known,
                           input logic signed [pwm_pkg::SAMPLE_W-1:0] known_val);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample   <= smp;
    in_ch.position <= pos;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_windowed.push_back(known ? known_val : window_product(smp, pos));
  endtask

  // Stops offering items and waits until every owed result has come out. As each
  // item yields exactly one result, the pipeline is empty at that point.
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_windowed.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [pwm_pkg::CFG_IDX_W-1:0] index,
                           input logic [pwm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    if (index == pwm_pkg::REG_BIN_WIDTH) begin
      bin_width_q = data[pwm_pkg::BW_W-1:0];
    end else if (index == pwm_pkg::REG_WINDOW_SCALE) begin
      window_scale_q = data[pwm_pkg::WS_W-1:0];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_registers(input logic [pwm_pkg::CFG_DATA_W-1:0] bw_data,
                                input logic [pwm_pkg::CFG_DATA_W-1:0] ws_data);
    quiesce();
    write_reg(pwm_pkg::REG_BIN_WIDTH, bw_data);
    write_reg(pwm_pkg::REG_WINDOW_SCALE, ws_data);
  endtask

  // Random items shaped like a real sample stream: positions mostly walk through
  // the current frame in order and wrap, with the odd jump anywhere in the
  // position range so that out-of-frame bins keep turning up.
  task automatic stream_frames(input int unsigned count);
    int unsigned                         span;
    logic [pwm_pkg::POS_W-1:0]           pos;
    logic signed [pwm_pkg::SAMPLE_W-1:0] smp;
    span = (bin_width_q == 0) ? FRAME_MAX : (32'h0100_0000 / bin_width_q);
    if (span == 0) begin
      span = 1;
    end
    if (span > FRAME_MAX) begin
      span = FRAME_MAX;
    end
    pos = '0;
    repeat (count) begin
      if ($urandom_range(0, 99) < 15) begin
        pos = pwm_pkg::POS_W'($urandom_range(0, FRAME_MAX - 1));
      end else if (pos + 1 >= span) begin
        pos = '0;
      end else begin
        pos = pos + 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          smp = 16'sh7FFF;
        end
        1: begin
          smp = 16'sh8000;
        end
        2: begin
          smp = pwm_pkg::SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
        end
        default: begin
          smp = pwm_pkg::SAMPLE_W'($urandom());
        end
      endcase
      push_item(smp, pos, 1'b0, '0);
    end
  endtask

  // Result side back-pressure, redrawn every cycle. At a zero rate the receiver
  // simply stays ready.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Each result taken is checked against the oldest expectation. A result with
  // nothing owed is reported and counted, and the run carries on regardless.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_windowed.size() == 0) begin
        $error("windowed: expected no item, got %0d", out_ch.windowed);
        mismatches++;
      end else if (out_ch.windowed !== pending_windowed[0]) begin
        $error("windowed: expected %0d, got %0d", pending_windowed[0], out_ch.windowed);
        mismatches++;
        void'(pending_windowed.pop_front());
      end else begin
        void'(pending_windowed.pop_front());
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** prolate_window_multiply: FAILED **");
      $finish;
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    in_ch.position = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    bin_width_q    = 24'd4096;
    window_scale_q = 25'd370727;
    mismatches     = 0;
    cycle_count    = 0;
    in_gap_pct     = 11;
    out_stall_pct  = 53;

    // Directed part. It opens on the reset values, then covers a zero window
    // scale (every result is zero), a two-point frame at full scale (the bin
    // centres lie well inside, so extreme samples saturate both ways), a bin
    // width written with bit 24 set (dropped, leaving a zero bin width so every
    // bin is outside the frame), a write to an index with no register behind it,
    // the narrowest and widest bin widths, and finally the reset values again.
    stim_table = '{
      item_row(16'sh7FFF, 12'd0),
      item_row(16'sh8000, 12'd4095),
      known_row(16'sd0, 12'd2048, 16'sd0),
      item_row(16'sd1, 12'd2047),
      item_row(-16'sd1, 12'd1),
      item_row(16'sd16384, 12'd2048),
      write_row(pwm_pkg::REG_WINDOW_SCALE, 25'd0),
      known_row(16'sh7FFF, 12'd100, 16'sd0),
      known_row(16'sh8000, 12'd3000, 16'sd0),
      write_row(pwm_pkg::REG_BIN_WIDTH, 25'd8388608),
      write_row(pwm_pkg::REG_WINDOW_SCALE, 25'h1FF_FFFF),
      known_row(16'sh7FFF, 12'd0, 16'sh7FFF),
      known_row(16'sh8000, 12'd1, 16'sh8000),
      item_row(16'sh7FFF, 12'd2),
      item_row(16'sh8000, 12'd4095),
      known_row(16'sd0, 12'd0, 16'sd0),
      write_row(pwm_pkg::REG_BIN_WIDTH, 25'h100_0000),
      write_row(pwm_pkg::REG_WINDOW_SCALE, 25'd16777216),
      item_row(16'sh7FFF, 12'd0),
      item_row(16'sh8000, 12'd4095),
      write_row(REG_SPARE, 25'h155_5555),
      item_row(16'sd12345, 12'd77),
      write_row(pwm_pkg::REG_BIN_WIDTH, 25'd1),
      write_row(pwm_pkg::REG_WINDOW_SCALE, 25'd370727),
      item_row(-16'sd20000, 12'd4095),
      item_row(16'sh7FFF, 12'd0),
      write_row(pwm_pkg::REG_BIN_WIDTH, 25'hFF_FFFF),
      write_row(pwm_pkg::REG_WINDOW_SCALE, 25'd1),
      item_row(16'sh7FFF, 12'd0),
      item_row(16'sh8000, 12'd4095),
      write_row(pwm_pkg::REG_BIN_WIDTH, 25'd4096),
      write_row(pwm_pkg::REG_WINDOW_SCALE, 25'd370727),
      item_row(16'sd21845, 12'd1365),
      item_row(-16'sd21846, 12'd2730)
    };

    // Synchronous reset held low from the start, released between edges.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        quiesce();
        write_reg(stim_table[i].index, stim_table[i].data);
      end else begin
        push_item(stim_table[i].smp, stim_table[i].pos,
                  stim_table[i].known, stim_table[i].known_val);
      end
    end

    // Random part. Sender rarely idles while the receiver stalls often.
    load_registers(25'd4096, 25'd370727);
    stream_frames(320);
    load_registers(25'd1, 25'd16777216);
    stream_frames(320);

    // Now the sender is the bursty side and the receiver rarely stalls.
    in_gap_pct    = 53;
    out_stall_pct = 11;
    load_registers(25'd8388608, 25'h1FF_FFFF);
    stream_frames(320);
    load_registers(25'($urandom_range(1, 24'hFF_FFFF)),
                   25'($urandom_range(0, 25'h1FF_FFFF)));
    stream_frames(320);

    // Full throughput on both sides.
    in_gap_pct    = 0;
    out_stall_pct = 0;
    load_registers(25'd65536, 25'd1482910);
    stream_frames(320);
    load_registers(25'(32'h0100_0000 / $urandom_range(2, FRAME_MAX)),
                   25'($urandom_range(32'h0010_0000, 32'h0080_0000)));
    stream_frames(300);

    // Drain, then give any stray result the chance to show itself.
    quiesce();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    if (mismatches == 0 && pending_windowed.size() == 0) begin
      $display("** prolate_window_multiply: PASSED **");
    end else begin
      $display("** prolate_window_multiply: FAILED **");
    end
    $finish;
  end

endmodule
